// ----- sv/sorted_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_defines
// assertion macros used by the sorted priority queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, checked on clk_i outside reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OCC_W        = 5;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // operation broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
  } spq_op_t;

  // one result item
  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
    logic [OCC_W-1:0]         occupancy;
  } spq_res_t;

endpackage

// ----- sv/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue held as a sorted row of compare-and-shift cells
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-------------------------------------
//   in      | in  | in_valid_i / in_stall_o | func_i, item_value_i, item_weight_i
//   out     | out | out_valid_o/out_stall_i | status_o, out_value_o, out_weight_o,
//           |     |                        | occupancy_o
//
// one item per cycle while in_stall_o is low: every cell compares its weight with the new one in
// parallel and the whole row inserts or shifts in that same edge
// a result item is registered into the output register, or into the skid stage while the output is stalled
// reset clears the entry count and the output valid flags; cell contents stay
// a stalled output keeps taking items until the skid stage fills, then stalls
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_weight_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [spq_pkg::DATA_W-1:0] out_value_o,
  output logic signed [spq_pkg::DATA_W-1:0] out_weight_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  // count widened so that its low occupancy bits can always be picked
  localparam int unsigned ExtW  = (CntW > spq_pkg::OCC_W) ? CntW : spq_pkg::OCC_W;

  logic [CntW-1:0]                   count_q, count_d;
  logic                              in_acc;
  logic                              full;
  logic                              empty;
  logic                              is_enq;
  spq_pkg::spq_op_t                  op;
  spq_pkg::spq_res_t                 res;
  spq_pkg::spq_res_t                 out_res;
  logic                              skid_valid;
  logic [ExtW-1:0]                   count_ext;

  logic                              take_w  [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] value_w [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] weight_w[CAPACITY];

  assign in_acc = in_valid_i && !in_stall_o;
  assign full   = count_q == CntW'(CAPACITY);
  assign empty  = count_q == '0;
  assign is_enq = func_i == spq_pkg::FUNC_ENQ;

  // broadcast to the row; a dropped enqueue or empty dequeue touches nothing
  assign op.ins    = in_acc && is_enq && !full;
  assign op.del    = in_acc && !is_enq && !empty;
  assign op.value  = item_value_i;
  assign op.weight = item_weight_i;

  // ---- row of cells, front of the queue at cell 0 ----
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                              take_left;
    logic signed [spq_pkg::DATA_W-1:0] left_value;
    logic signed [spq_pkg::DATA_W-1:0] left_weight;
    logic signed [spq_pkg::DATA_W-1:0] right_value;
    logic signed [spq_pkg::DATA_W-1:0] right_weight;

    if (g == 0) begin : g_first
      assign take_left   = 1'b0;
      assign left_value  = '0;
      assign left_weight = '0;
    end else begin : g_mid
      assign take_left   = take_w[g-1];
      assign left_value  = value_w[g-1];
      assign left_weight = weight_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_value  = '0;
      assign right_weight = '0;
    end else begin : g_inner
      assign right_value  = value_w[g+1];
      assign right_weight = weight_w[g+1];
    end

    spq_cell #(
      .Idx (g),
      .CntW(CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .count_i       (count_q),
      .take_left_i   (take_left),
      .left_value_i  (left_value),
      .left_weight_i (left_weight),
      .right_value_i (right_value),
      .right_weight_i(right_weight),
      .take_o        (take_w[g]),
      .value_o       (value_w[g]),
      .weight_o      (weight_w[g])
    );
  end

  // ---- entry count ----
  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + 1'b1;
    end else if (op.del) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // ---- result item ----
  assign count_ext = ExtW'(count_d);

  always_comb begin
    res.value     = '0;
    res.weight    = '0;
    res.occupancy = count_ext[spq_pkg::OCC_W-1:0];
    if (is_enq) begin
      res.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQ;
    end else if (empty) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      // front entry leaves
      res.status = spq_pkg::ST_DEQ;
      res.value  = value_w[0];
      res.weight = weight_w[0];
    end
  end

  spq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (in_acc),
    .res_i       (res),
    .stall_o     (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res),
    .skid_valid_o(skid_valid)
  );

  assign status_o     = out_res.status;
  assign out_value_o  = out_res.value;
  assign out_weight_o = out_res.weight;
  assign occupancy_o  = out_res.occupancy;

  // ---- checks ----
  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid_o, "skid full, output empty")
  `SPQ_ASSERT_NEXT(a_full_drop, in_acc && is_enq && full, $stable(count_q), "full drop moved count")
  `SPQ_ASSERT_NEXT(a_deq_count, op.del, count_q + 1'b1 == $past(count_q), "dequeue kept count")

endmodule

// ----- sv/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: compares, then keeps, loads or shifts
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                             clk_i,
  input  spq_pkg::spq_op_t                 op_i,
  input  logic [CntW-1:0]                  count_i,
  input  logic                             take_left_i,
  input  logic signed [spq_pkg::DATA_W-1:0] left_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0] left_weight_i,
  input  logic signed [spq_pkg::DATA_W-1:0] right_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0] right_weight_i,
  output logic                             take_o,
  output logic signed [spq_pkg::DATA_W-1:0] value_o,
  output logic signed [spq_pkg::DATA_W-1:0] weight_o
);

  logic signed [spq_pkg::DATA_W-1:0] value_q, value_d;
  logic signed [spq_pkg::DATA_W-1:0] weight_q, weight_d;
  logic                              occ;
  logic                              gt;

  assign occ = CntW'(Idx) < count_i;
  assign gt  = occ && (weight_q > op_i.weight);
  // slot at or behind the insert point
  assign take_o = gt || (count_i == CntW'(Idx));

  always_comb begin
    value_d  = value_q;
    weight_d = weight_q;
    if (op_i.ins && take_o) begin
      if (take_left_i) begin
        value_d  = left_value_i;
        weight_d = left_weight_i;
      end else begin
        value_d  = op_i.value;
        weight_d = op_i.weight;
      end
    end else if (op_i.del) begin
      value_d  = right_value_i;
      weight_d = right_weight_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    weight_q <= weight_d;
  end

  assign value_o  = value_q;
  assign weight_o = weight_q;

endmodule

// ----- sv/spq_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_out_buf
// output register with a skid stage for result items
// ----------------------------------------------------------------------------
module spq_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  spq_pkg::spq_res_t res_i,
  output logic              stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::spq_res_t out_res_o,
  output logic              skid_valid_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  spq_pkg::spq_res_t out_res_q, out_res_d;
  spq_pkg::spq_res_t skid_res_q, skid_res_d;
  logic              out_take;

  assign out_take = out_valid_q && !out_stall_i;
  assign stall_o  = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    skid_res_d   = skid_res_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || out_take) begin
        out_res_d   = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_res_d   = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_res_o    = out_res_q;
  assign skid_valid_o = skid_valid_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted priority queue: a shadow list in a small
// class predicts status, removed entry and occupancy for every accepted item,
// while random gaps and stalls on both channels vary the handshake timing
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QUEUE_DEPTH  = spq_pkg::CAPACITY_DEF;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned CHUNK_ITEMS  = 50;
  localparam int unsigned CHUNK_COUNT  = 22;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic signed [spq_pkg::DATA_W-1:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [spq_pkg::DATA_W-1:0] W_MIN = 32'sh8000_0000;

  // how a random chunk leans between enqueue and dequeue
  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_e;

  // --------------------------------------------------------------------------
  // shadow of the sorted list plus the results it still owes
  // --------------------------------------------------------------------------
  class order_tracker;
    typedef struct {
      logic signed [spq_pkg::DATA_W-1:0] value;
      logic signed [spq_pkg::DATA_W-1:0] weight;
    } slot_t;

    int unsigned       depth;
    slot_t             stored[$];
    spq_pkg::spq_res_t pending_results[$];
    int unsigned       mismatches;

    function new(int unsigned cap);
      depth      = cap;
      mismatches = 0;
    endfunction

    // work out the result of one accepted item and queue it
    function void take_item(logic f, logic signed [spq_pkg::DATA_W-1:0] v,
                            logic signed [spq_pkg::DATA_W-1:0] w);
      spq_pkg::spq_res_t res;
      slot_t             s;
      int                pos;
      res.value  = '0;
      res.weight = '0;
      if (f == spq_pkg::FUNC_ENQ) begin
        if (stored.size() >= depth) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // behind every entry of lower or equal weight
          pos = stored.size();
          for (int i = 0; i < stored.size(); i++) begin
            if (stored[i].weight > w) begin
              pos = i;
              break;
            end
          end
          s.value  = v;
          s.weight = w;
          stored.insert(pos, s);
          res.status = spq_pkg::ST_ENQ;
        end
      end else begin
        if (stored.size() == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          s          = stored.pop_front();
          res.value  = s.value;
          res.weight = s.weight;
          res.status = spq_pkg::ST_DEQ;
        end
      end
      res.occupancy = spq_pkg::OCC_W'(stored.size());
      pending_results.push_back(res);
    endfunction

    // compare one accepted result against the oldest prediction
    function void match_result(logic [1:0] st, logic signed [spq_pkg::DATA_W-1:0] v,
                               logic signed [spq_pkg::DATA_W-1:0] w,
                               logic [spq_pkg::OCC_W-1:0] occ);
      spq_pkg::spq_res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with none pending: status %0d value %0d weight %0d occ %0d",
                   $realtime, st, v, w, occ);
        return;
      end
      want = pending_results.pop_front();
      if (want.status !== st || want.value !== v || want.weight !== w ||
          want.occupancy !== occ) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: mismatch: status %0d/%0d value %0d/%0d weight %0d/%0d occ %0d/%0d",
                   $realtime, want.status, st, want.value, v, want.weight, w,
                   want.occupancy, occ);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              func_i;
  logic signed [spq_pkg::DATA_W-1:0] item_value_i;
  logic signed [spq_pkg::DATA_W-1:0] item_weight_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [1:0]                        status_o;
  logic signed [spq_pkg::DATA_W-1:0] out_value_o;
  logic signed [spq_pkg::DATA_W-1:0] out_weight_o;
  logic [spq_pkg::OCC_W-1:0]         occupancy_o;

  order_tracker tracker;
  int unsigned  cycle_count;
  bit           tx_quiet;      // sender offers back to back
  bit           rx_quiet;      // receiver starts no new stall burst
  bit           hold_request;  // asks the receiver for one long hold-off

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .item_value_i (item_value_i),
    .item_weight_i(item_weight_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .out_weight_o (out_weight_o),
    .occupancy_o  (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // weights crowd around a few small values so ties happen often
  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2, 3, 4, 5: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // sampling at the rising edge: accepted items feed the shadow list,
  // accepted results are checked against it
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        tracker.take_item(func_i, item_value_i, item_weight_i);
      if (out_valid_o && !out_stall_i)
        tracker.match_result(status_o, out_value_o, out_weight_o, occupancy_o);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, quiet stretches and the long hold-off,
  // all driven at the falling edge
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall_left;
    int unsigned run_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    run_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        // long hold-off so the block backs up and stalls its input
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (run_left > 0 || rx_quiet) begin
        out_stall_i <= 1'b0;
        if (run_left > 0) run_left--;
      end else begin
        stall_left = pick_gap(1'b0);
        run_left   = $urandom_range(0, 8);
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender: offer one item after a random gap and hold it until taken;
  // entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(logic f, logic signed [spq_pkg::DATA_W-1:0] v,
                           logic signed [spq_pkg::DATA_W-1:0] w);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i        <= f;
    item_value_i  <= v;
    item_weight_i <= w;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one random chunk; mostly enqueue or mostly dequeue walks occupancy
  // between empty and full
  task automatic run_chunk(mix_e mix, int unsigned count);
    int unsigned enq_pct;
    case (mix)
      MIX_FILL:  enq_pct = 80;
      MIX_DRAIN: enq_pct = 25;
      default:   enq_pct = 50;
    endcase
    repeat (count) begin
      if ($urandom_range(99) < enq_pct)
        send_item(spq_pkg::FUNC_ENQ, $urandom, pick_weight());
      else
        send_item(spq_pkg::FUNC_DEQ, $urandom, $urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic signed [spq_pkg::DATA_W-1:0] w;
    logic signed [spq_pkg::DATA_W-1:0] v;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = spq_pkg::FUNC_ENQ;
    item_value_i  = '0;
    item_weight_i = '0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    hold_request  = 1'b0;
    cycle_count   = 0;
    tracker       = new(QUEUE_DEPTH);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // dequeue on empty
    send_item(spq_pkg::FUNC_DEQ, W_MAX, W_MIN);

    // fill to capacity with extreme weights and values and a run of ties
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i % 16)
        0: w = W_MAX;
        1: w = W_MIN;
        2: w = 0;
        3: w = -1;
        4: w = 1;
        5, 6, 7, 12: w = 3;
        8: w = W_MIN;
        9: w = W_MAX;
        default: w = i - 12;
      endcase
      case (i % 16)
        0: v = W_MAX;
        1: v = W_MIN;
        2: v = 0;
        3: v = -1;
        default: v = $urandom;
      endcase
      send_item(spq_pkg::FUNC_ENQ, v, w);
    end

    // enqueue into a full queue is dropped
    send_item(spq_pkg::FUNC_ENQ, $urandom, 0);
    repeat (3) send_item(spq_pkg::FUNC_DEQ, 0, 0);

    // random chunks; two of them, chunks 2 and 15, send back to back under a long hold-off
    for (int c = 0; c < CHUNK_COUNT; c++) begin
      tx_quiet = ($urandom_range(4) == 0);
      rx_quiet = ($urandom_range(4) == 0);
      if (c == 2 || c == 15) begin
        tx_quiet     = 1'b1;
        rx_quiet     = 1'b0;
        hold_request = 1'b1;
        run_chunk(MIX_FILL, CHUNK_ITEMS);
      end else begin
        run_chunk(mix_e'($urandom_range(2)), CHUNK_ITEMS);
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
